@@ rtl/npic_pkg.sv @@
// ============================================================================
// npic_pkg - shared definitions for the nested priority interrupt controller
// Widths, register indexes, state and result structs, and the mask helpers.
// ============================================================================
package npic_pkg;

    localparam int NUM_VECTORS  = 14;
    localparam int NUM_LEVELS   = 8;
    localparam int LEVEL_W      = 3;
    localparam int VEC_IDX_W    = 4;
    localparam int DEPTH_W      = 3;
    localparam int STACK_SLOTS  = NUM_LEVELS - 1;
    localparam int STACK_IDX_W  = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int LEVELS_W     = NUM_VECTORS * LEVEL_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = LEVELS_W;

    localparam logic [LEVEL_W-1:0]     LOWEST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);
    localparam logic [LEVELS_W-1:0]    LEVELS_RESET = '1;
    localparam logic [DEPTH_W-1:0]     STACK_FULL   = DEPTH_W'(STACK_SLOTS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VECTOR_LEVELS = 2'd0,
        REG_VECTOR_ENABLE = 2'd1,
        REG_MASTER_ENABLE = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        MODE_RAISE    = 1'b0,
        MODE_COMPLETE = 1'b1
    } item_mode_t;

    typedef struct packed {
        logic [LEVELS_W-1:0]    levels;
        logic [NUM_VECTORS-1:0] enable;
        logic                   master;
    } cfg_t;

    typedef struct packed {
        logic [NUM_VECTORS-1:0] pending;
        logic [LEVEL_W-1:0]     level;
        logic [DEPTH_W-1:0]     depth;
    } ctl_state_t;

    typedef struct packed {
        logic                   dispatch_valid;
        logic [VEC_IDX_W-1:0]   dispatch_vector;
        logic [LEVEL_W-1:0]     current_priority;
        logic [NUM_VECTORS-1:0] allowed_mask;
        logic [NUM_VECTORS-1:0] pending_out;
        logic [DEPTH_W-1:0]     nest_count;
        logic                   error_code;
    } result_t;

    // Level of one vector, codes past the lowest level fold onto it.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [LEVELS_W-1:0] levels,
                                                    input logic [VEC_IDX_W-1:0] v);
        logic [LEVEL_W-1:0] lv;
        lv = levels[LEVEL_W*v +: LEVEL_W];
        return (lv > LOWEST_LEVEL) ? LOWEST_LEVEL : lv;
    endfunction

    // Enabled vectors whose level is strictly above (numerically below) the given one.
    function automatic logic [NUM_VECTORS-1:0] allowed_at(input logic [LEVELS_W-1:0] levels,
                                                          input logic [NUM_VECTORS-1:0] enable,
                                                          input logic [LEVEL_W-1:0] level);
        logic [NUM_VECTORS-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_VECTORS; i++) begin
            m[i] = enable[i] && (level_of(levels, VEC_IDX_W'(i)) < level);
        end
        return m;
    endfunction

    function automatic logic [VEC_IDX_W-1:0] lowest_set(input logic [NUM_VECTORS-1:0] bits);
        logic [VEC_IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_VECTORS - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = VEC_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/nested_priority_interrupt_controller.sv @@
// ============================================================================
// nested_priority_interrupt_controller - nested priority-level interrupt control
// Latches interrupt requests, dispatches the lowest allowed vector and keeps a
// stack of preempted priority levels that complete words restore.
// ============================================================================
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  s_      | in        | s_valid / s_ready      | s_mode, s_raise_flags
//  m_      | out       | m_valid / m_ready      | dispatch, level, masks, depth
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One word per cycle sustained while m_ready stays high. A word is held in the
//  input register, then the core updates pending, level and stack and loads the
//  result register, which drives m_valid and the result word until it is taken.
//  A stalled m_ side holds the result; the input register still takes one
//  more word, then s_ready drops until the result drains.
//  Synchronous active-low reset clears control state; the level stack needs
//  no clearing since only pushed slots are ever popped. cfg_ready is always high.
// ============================================================================
module nested_priority_interrupt_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [npic_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [npic_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [npic_pkg::NUM_VECTORS-1:0]    s_raise_flags,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_dispatch_valid,
    output logic [npic_pkg::VEC_IDX_W-1:0]      m_dispatch_vector,
    output logic [npic_pkg::LEVEL_W-1:0]        m_current_priority,
    output logic [npic_pkg::NUM_VECTORS-1:0]    m_allowed_mask,
    output logic [npic_pkg::NUM_VECTORS-1:0]    m_pending_out,
    output logic [npic_pkg::DEPTH_W-1:0]        m_nest_count,
    output logic                                m_error_code
);
    import npic_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;

    // controller state
    ctl_state_t state_reg;
    ctl_state_t state_next;

    // input register
    logic                   in_valid_reg;
    logic                   in_mode_reg;
    logic [NUM_VECTORS-1:0] in_flags_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_res;

    logic                   advance;
    logic                   fire;
    logic                   push;
    logic [LEVEL_W-1:0]     saved_level;
    logic [STACK_IDX_W-1:0] rd_index;

    // Result register can load when empty or being drained this cycle.
    assign advance   = !out_valid_reg || m_ready;
    // Input register word moves into the core only when the result slot frees.
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Write registers; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.levels <= LEVELS_RESET;
            cfg_reg.enable <= '0;
            cfg_reg.master <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VECTOR_LEVELS: cfg_reg.levels <= cfg_data;
                REG_VECTOR_ENABLE: cfg_reg.enable <= cfg_data[NUM_VECTORS-1:0];
                REG_MASTER_ENABLE: cfg_reg.master <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: take a new word whenever the current one moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mode_reg  <= s_mode;
            in_flags_reg <= s_raise_flags;
        end
    end

    // Top of stack sits one below the depth; an empty stack reads slot zero
    // but the core ignores it then.
    assign rd_index = (state_reg.depth == '0) ? '0
                    : STACK_IDX_W'(state_reg.depth - DEPTH_W'(1));

    npic_stack u_stack (
        .aclk     (aclk),
        .push_en  (fire && push),
        .wr_index (STACK_IDX_W'(state_reg.depth)),
        .wr_level (state_reg.level),
        .rd_index (rd_index),
        .rd_level (saved_level)
    );

    npic_core u_core (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .mode        (in_mode_reg),
        .raise_flags (in_flags_reg),
        .saved_level (saved_level),
        .nxt         (state_next),
        .push        (push),
        .res         (core_res)
    );

    // Advance state only when a word is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pending <= '0;
            state_reg.level   <= LOWEST_LEVEL;
            state_reg.depth   <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: load on fire, drop valid once taken with nothing new.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= core_res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_dispatch_valid   = out_reg.dispatch_valid;
    assign m_dispatch_vector  = out_reg.dispatch_vector;
    assign m_current_priority = out_reg.current_priority;
    assign m_allowed_mask     = out_reg.allowed_mask;
    assign m_pending_out      = out_reg.pending_out;
    assign m_nest_count       = out_reg.nest_count;
    assign m_error_code       = out_reg.error_code;

endmodule

@@ rtl/npic_stack.sv @@
// ============================================================================
// npic_stack - saved priority level stack
// Register file of saved levels, written on push, read at the top of stack.
// ============================================================================
module npic_stack (
    input  logic                           aclk,
    input  logic                           push_en,
    input  logic [npic_pkg::STACK_IDX_W-1:0] wr_index,
    input  logic [npic_pkg::LEVEL_W-1:0]     wr_level,
    input  logic [npic_pkg::STACK_IDX_W-1:0] rd_index,
    output logic [npic_pkg::LEVEL_W-1:0]     rd_level
);
    import npic_pkg::*;

    logic [LEVEL_W-1:0] slot_reg [STACK_SLOTS];

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_reg[wr_index] <= wr_level;
        end
    end

    assign rd_level = slot_reg[rd_index];

endmodule

@@ rtl/npic_core.sv @@
// ============================================================================
// npic_core - dispatch and restore logic for one item
// Merges requests, picks the lowest allowed pending vector, pushes or pops.
// ============================================================================
module npic_core (
    input  npic_pkg::cfg_t                  cfg,
    input  npic_pkg::ctl_state_t            cur,
    input  logic                            mode,
    input  logic [npic_pkg::NUM_VECTORS-1:0] raise_flags,
    input  logic [npic_pkg::LEVEL_W-1:0]     saved_level,
    output npic_pkg::ctl_state_t            nxt,
    output logic                            push,
    output npic_pkg::result_t               res
);
    import npic_pkg::*;

    logic [NUM_VECTORS-1:0] pend_raised;
    logic [NUM_VECTORS-1:0] ready_bits;
    logic                   do_dispatch;
    logic [VEC_IDX_W-1:0]   vec;
    logic                   underflow;

    always_comb begin
        pend_raised = cur.pending | raise_flags;
        ready_bits  = pend_raised & allowed_at(cfg.levels, cfg.enable, cur.level);
        do_dispatch = (mode == MODE_RAISE) && cfg.master && (ready_bits != '0)
                      && (cur.depth < STACK_FULL);
        vec         = lowest_set(ready_bits);
        underflow   = (mode == MODE_COMPLETE) && (cur.depth == '0);

        nxt = cur;
        if (mode == MODE_RAISE) begin
            nxt.pending = pend_raised;
            if (do_dispatch) begin
                nxt.pending[vec] = 1'b0;
                nxt.level        = level_of(cfg.levels, vec);
                nxt.depth        = cur.depth + DEPTH_W'(1);
            end
        end else if (!underflow) begin
            nxt.level = saved_level;
            nxt.depth = cur.depth - DEPTH_W'(1);
        end
        push = do_dispatch;

        res.dispatch_valid   = do_dispatch;
        res.dispatch_vector  = do_dispatch ? vec : '0;
        res.current_priority = nxt.level;
        res.allowed_mask     = allowed_at(cfg.levels, cfg.enable, nxt.level);
        res.pending_out      = nxt.pending;
        res.nest_count       = nxt.depth;
        res.error_code       = underflow;
    end

endmodule

@@ rtl/npic_checker.sv @@
// ============================================================================
// npic_checker - port-level checks for the interrupt controller
// Watches the result channel for handshake and result consistency.
// ============================================================================
module npic_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_dispatch_valid,
    input  logic [npic_pkg::VEC_IDX_W-1:0]      m_dispatch_vector,
    input  logic [npic_pkg::DEPTH_W-1:0]        m_nest_count,
    input  logic                                m_error_code
);
    import npic_pkg::*;

    // Hold a stalled result word.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dispatch_vector)
                                && $stable(m_nest_count))
        else $error("stalled result word changed");

    a_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dispatch_valid |-> m_dispatch_vector == '0)
        else $error("vector nonzero without dispatch");

    a_dispatch_nests: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dispatch_valid |-> m_nest_count != '0 && !m_error_code)
        else $error("dispatch without a saved level");

    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code |-> m_nest_count == '0 && !m_dispatch_valid)
        else $error("underflow flagged with nested levels");

endmodule

bind nested_priority_interrupt_controller npic_checker u_npic_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_dispatch_valid  (m_dispatch_valid),
    .m_dispatch_vector (m_dispatch_vector),
    .m_nest_count      (m_nest_count),
    .m_error_code      (m_error_code)
);

@@ tb/npic_result_checker.sv @@
// ============================================================================
// npic_result_checker - result prediction and comparison for the interrupt controller
// Tracks pending, level and the saved-level stack for every accepted input word,
// then compares each accepted result word, field by field, with the oldest
// prediction.
// ============================================================================
module npic_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [npic_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [npic_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_mode,
    input  logic [npic_pkg::NUM_VECTORS-1:0]    s_raise_flags,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_dispatch_valid,
    input  logic [npic_pkg::VEC_IDX_W-1:0]      m_dispatch_vector,
    input  logic [npic_pkg::LEVEL_W-1:0]        m_current_priority,
    input  logic [npic_pkg::NUM_VECTORS-1:0]    m_allowed_mask,
    input  logic [npic_pkg::NUM_VECTORS-1:0]    m_pending_out,
    input  logic [npic_pkg::DEPTH_W-1:0]        m_nest_count,
    input  logic                                m_error_code,
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  checked_count
);
    import npic_pkg::*;

    // shadow configuration
    logic [LEVELS_W-1:0]    level_map;
    logic [NUM_VECTORS-1:0] unmask;
    logic                   global_on;

    // shadow controller state
    logic [NUM_VECTORS-1:0] pend;
    logic [LEVEL_W-1:0]     cur_level;
    logic [LEVEL_W-1:0]     level_stack [STACK_SLOTS];
    logic [DEPTH_W-1:0]     nest;

    result_t                predicted_results [$];
    result_t                want;
    int                     mismatches = 0;
    int                     checked = 0;

    function automatic logic [LEVEL_W-1:0] vec_level(input int v);
        logic [LEVEL_W-1:0] code;
        code = level_map[v*LEVEL_W +: LEVEL_W];
        if (code > LOWEST_LEVEL) code = LOWEST_LEVEL;
        return code;
    endfunction

    // Enabled vectors that may preempt the given level.
    function automatic logic [NUM_VECTORS-1:0] preempt_mask(input logic [LEVEL_W-1:0] level);
        logic [NUM_VECTORS-1:0] m;
        m = '0;
        for (int v = 0; v < NUM_VECTORS; v++) begin
            m[v] = unmask[v] && (vec_level(v) < level);
        end
        return m;
    endfunction

    // Apply one input word to the shadow state and return the result it yields.
    function automatic result_t next_dispatch(input item_mode_t mode,
                                              input logic [NUM_VECTORS-1:0] flags);
        result_t                r;
        logic [NUM_VECTORS-1:0] ready_bits;
        int                     pick;
        r = '0;
        if (mode == MODE_RAISE) begin
            pend = pend | flags;
            ready_bits = pend & preempt_mask(cur_level);
            if (global_on && ready_bits != '0 && nest < STACK_FULL) begin
                pick = 0;
                while (!ready_bits[pick]) pick++;
                pend[pick] = 1'b0;
                level_stack[nest] = cur_level;
                nest = nest + 1'b1;
                cur_level = vec_level(pick);
                r.dispatch_valid = 1'b1;
                r.dispatch_vector = VEC_IDX_W'(pick);
            end
        end else if (nest == '0) begin
            r.error_code = 1'b1;
        end else begin
            nest = nest - 1'b1;
            cur_level = level_stack[nest];
        end
        r.current_priority = cur_level;
        r.allowed_mask = preempt_mask(cur_level);
        r.pending_out = pend;
        r.nest_count = nest;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            level_map = LEVELS_RESET;
            unmask = '0;
            global_on = 1'b0;
            pend = '0;
            cur_level = LOWEST_LEVEL;
            nest = '0;
            predicted_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VECTOR_LEVELS: level_map = cfg_data[LEVELS_W-1:0];
                    REG_VECTOR_ENABLE: unmask = cfg_data[NUM_VECTORS-1:0];
                    REG_MASTER_ENABLE: global_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted_results.push_back(next_dispatch(item_mode_t'(s_mode), s_raise_flags));
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result word accepted with no prediction waiting");
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("dispatch_valid", 64'(want.dispatch_valid),
                                64'(m_dispatch_valid));
                    check_field("dispatch_vector", 64'(want.dispatch_vector),
                                64'(m_dispatch_vector));
                    check_field("current_priority", 64'(want.current_priority),
                                64'(m_current_priority));
                    check_field("allowed_mask", 64'(want.allowed_mask),
                                64'(m_allowed_mask));
                    check_field("pending_out", 64'(want.pending_out),
                                64'(m_pending_out));
                    check_field("nest_count", 64'(want.nest_count),
                                64'(m_nest_count));
                    check_field("error_code", 64'(want.error_code),
                                64'(m_error_code));
                    checked++;
                end
            end
        end
        outstanding <= predicted_results.size();
        fail_count <= mismatches;
        checked_count <= checked;
    end

endmodule

@@ tb/tb_nested_priority_interrupt_controller.sv @@
// ============================================================================
// tb_nested_priority_interrupt_controller - stimulus and verdict for the controller
// Drives configuration and input words with random idling on both channels,
// walks directed nesting, masking and empty-stack cases, then random raise and
// complete sequences under many register settings; a checker module beside the
// block predicts and compares every result word.
// ============================================================================
module tb_nested_priority_interrupt_controller;
    import npic_pkg::*;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int RANDOM_WORDS = 1000;
    localparam int CALM_TAIL    = 150;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_mode = 1'b0;
    logic [NUM_VECTORS-1:0]  s_raise_flags = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b1;
    logic                    m_dispatch_valid;
    logic [VEC_IDX_W-1:0]    m_dispatch_vector;
    logic [LEVEL_W-1:0]      m_current_priority;
    logic [NUM_VECTORS-1:0]  m_allowed_mask;
    logic [NUM_VECTORS-1:0]  m_pending_out;
    logic [DEPTH_W-1:0]      m_nest_count;
    logic                    m_error_code;

    int fail_count;
    int outstanding;
    int checked_count;

    int words_sent = 0;
    int reg_writes = 0;
    bit gaps_on = 1'b0;   // random idling allowed in this phase
    bit quiet = 1'b0;     // tail of the run: no idling at all

    nested_priority_interrupt_controller u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_raise_flags      (s_raise_flags),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_dispatch_valid   (m_dispatch_valid),
        .m_dispatch_vector  (m_dispatch_vector),
        .m_current_priority (m_current_priority),
        .m_allowed_mask     (m_allowed_mask),
        .m_pending_out      (m_pending_out),
        .m_nest_count       (m_nest_count),
        .m_error_code       (m_error_code)
    );

    npic_result_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_raise_flags      (s_raise_flags),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_dispatch_valid   (m_dispatch_valid),
        .m_dispatch_vector  (m_dispatch_vector),
        .m_current_priority (m_current_priority),
        .m_allowed_mask     (m_allowed_mask),
        .m_pending_out      (m_pending_out),
        .m_nest_count       (m_nest_count),
        .m_error_code       (m_error_code),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .checked_count      (checked_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #3200000;
        $display("FAILURE");
        $finish;
    end

    // Result side: stall in random bursts while the phase allows it.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && gaps_on && !quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Present one input word and hold it until accepted. Valid stays high on
    // return so back-to-back words never drop it; drop it only for a gap.
    task automatic send_word(input item_mode_t mode, input logic [NUM_VECTORS-1:0] flags);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_raise_flags <= flags;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Drop valid and hold off until every predicted result word has drained.
    // Every word yields a result, so an empty prediction store means idle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write one register; then idle with valid low so the next write
    // raises it in a later step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_data();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_DATA_W-1:0];
    endfunction

    // Vector v at level 7 - (v mod 8): a full descending ladder for nesting.
    function automatic logic [LEVELS_W-1:0] ladder_levels();
        logic [LEVELS_W-1:0] lv;
        for (int v = 0; v < NUM_VECTORS; v++) begin
            lv[v*LEVEL_W +: LEVEL_W] = LOWEST_LEVEL - LEVEL_W'(v % NUM_LEVELS);
        end
        return lv;
    endfunction

    // Mostly sparse request patterns so nesting builds up one vector at a time.
    function automatic logic [NUM_VECTORS-1:0] pick_flags();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4, 5: return NUM_VECTORS'(1) << $urandom_range(0, NUM_VECTORS - 1);
            6:       return '1;
            default: return NUM_VECTORS'($urandom);
        endcase
    endfunction

    // New register setting for a phase; upper data bits stay random so that
    // bits past each register's width get exercised too.
    task automatic random_setting();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 5))
            0:       d = '0;
            1:       d = '1;
            2:       d = ladder_levels();
            default: d = rand_data();
        endcase
        write_reg(REG_VECTOR_LEVELS, d);
        d = rand_data();
        case ($urandom_range(0, 5))
            0: d[NUM_VECTORS-1:0] = '1;
            1: d[NUM_VECTORS-1:0] = '0;
            default: ;
        endcase
        write_reg(REG_VECTOR_ENABLE, d);
        d = rand_data();
        d[0] = ($urandom_range(0, 5) != 0);
        write_reg(REG_MASTER_ENABLE, d);
    endtask

    // One handler-like sequence: a few raises nest dispatches, then completes
    // unwind them, sometimes past the bottom; an odd random word is mixed in.
    task automatic run_sequence();
        int n_raise;
        int n_done;
        n_raise = $urandom_range(1, 6);
        n_done = $urandom_range(0, 8);
        repeat (n_raise) send_word(MODE_RAISE, pick_flags());
        if ($urandom_range(0, 9) == 0) send_word(item_mode_t'($urandom_range(0, 1)), pick_flags());
        repeat (n_done) begin
            send_word(MODE_COMPLETE, ($urandom_range(0, 3) == 0) ? pick_flags() : '0);
        end
    endtask

    initial begin
        int target;
        int phase_len;
        int phase_start;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part --------------------------------------------------
        // Reset setting: complete on an empty stack, raise with master off.
        send_word(MODE_COMPLETE, '0);
        send_word(MODE_RAISE, '1);
        send_word(MODE_RAISE, '0);
        wait_idle();

        // Ladder levels, vector 0 masked although it is the lowest pending bit.
        write_reg(REG_VECTOR_LEVELS, ladder_levels());
        write_reg(REG_VECTOR_ENABLE, {{(CFG_DATA_W-NUM_VECTORS){1'b1}}, 14'h3FFE});
        write_reg(REG_MASTER_ENABLE, 42'h1);
        write_reg(REG_NONE, rand_data());

        // Zero-flag raises retry dispatch and nest all the way to a full stack.
        repeat (7) send_word(MODE_RAISE, '0);
        send_word(MODE_RAISE, '1);
        // Flags on a complete word are ignored; unwind and go one past empty.
        send_word(MODE_COMPLETE, '1);
        repeat (7) send_word(MODE_COMPLETE, '0);
        wait_idle();

        // Every vector at the top level: one dispatch, then nothing preempts.
        write_reg(REG_VECTOR_LEVELS, '0);
        send_word(MODE_RAISE, '1);
        send_word(MODE_RAISE, '0);
        send_word(MODE_COMPLETE, '0);
        wait_idle();

        // Every vector at the bottom level: nothing is ever allowed.
        write_reg(REG_VECTOR_LEVELS, '1);
        write_reg(REG_VECTOR_ENABLE, '1);
        send_word(MODE_RAISE, 14'h2AAA);
        send_word(MODE_COMPLETE, 14'h1555);
        wait_idle();

        // ---- random part ----------------------------------------------------
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            wait_idle();
            gaps_on = ($urandom_range(0, 3) != 0);
            random_setting();
            phase_len = $urandom_range(80, 160);
            phase_start = words_sent;
            quiet = (words_sent >= target - CALM_TAIL);
            // Once in the tail, stay in this phase so nothing idles until the end.
            while ((words_sent - phase_start < phase_len || quiet) && words_sent < target) begin
                run_sequence();
                quiet = (words_sent >= target - CALM_TAIL);
                // Hold off mid-phase until the result side has drained.
                if (!quiet && words_sent - phase_start >= phase_len / 2
                    && words_sent - phase_start < phase_len / 2 + 8) begin
                    wait_idle();
                end
            end
        end

        // ---- wrap-up --------------------------------------------------------
        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d input words and %0d checked result words over %0d register writes,",
                 words_sent, checked_count, reg_writes);
        $display("including full nesting, masked pending vectors and empty-stack completes.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
